FILE: rtl/acsm_pkg.sv
// Shared types, register codes and constants of the adaptive CUSUM scale monitor.
// Used by the channel interfaces and by the core; depends on nothing else.
package acsm_pkg;

   localparam int unsigned MAX_SAMPLES = 65536;
   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned CSR_DATA_W  = 48;
   localparam logic [31:0] EXP_085_Q16 = 32'd55706;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_K_HIGH       = 4'd0,
      REG_K_LOW        = 4'd1,
      REG_H_BASE       = 4'd2,
      REG_H_DELTA      = 4'd3,
      REG_UPDATE_DELAY = 4'd4,
      REG_PHASE1_COUNT = 4'd5,
      REG_PHASE1_SUM   = 4'd6,
      REG_SHAPE_VALUE  = 4'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      STATUS_IN_CONTROL = 2'd0,
      STATUS_ALARM      = 2'd1,
      STATUS_CAP        = 2'd2
   } status_type;

   typedef struct packed {
      logic [31:0] sample;
   } req_word_type;

   typedef struct packed {
      logic [15:0] step_index;
      logic [31:0] cusum_high;
      logic [31:0] cusum_low;
      logic [31:0] limit;
      logic [31:0] scale_estimate;
      logic [1:0]  status;
   } rsp_word_type;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_word_type;

   // 2^(-2^-(i+1)) in Q0.32.
   function automatic logic [31:0] exp_tab(input logic [3:0] i);
      logic [31:0] v;
      case (i)
         4'd0:    v = 32'd3037000500;
         4'd1:    v = 32'd3611622603;
         4'd2:    v = 32'd3938502376;
         4'd3:    v = 32'd4112874773;
         4'd4:    v = 32'd4202935003;
         4'd5:    v = 32'd4248701965;
         4'd6:    v = 32'd4271771996;
         4'd7:    v = 32'd4283353945;
         4'd8:    v = 32'd4289156690;
         4'd9:    v = 32'd4292061010;
         4'd10:   v = 32'd4293513907;
         4'd11:   v = 32'd4294240540;
         4'd12:   v = 32'd4294603903;
         4'd13:   v = 32'd4294785595;
         4'd14:   v = 32'd4294876445;
         default: v = 32'd4294921870;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/acsm_channels.sv
// Valid/ready channel interfaces of the adaptive CUSUM scale monitor.
// Depends on acsm_pkg for the word types.
interface acsm_req_if;
   logic                  valid;
   logic                  ready;
   acsm_pkg::req_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface acsm_rsp_if;
   logic                  valid;
   logic                  ready;
   acsm_pkg::rsp_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface acsm_csr_if;
   logic                  valid;
   logic                  ready;
   acsm_pkg::csr_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/adaptive_cusum_scale_monitor_core.sv
// Adaptive CUSUM scale monitor core: sequencer, shared multiplier and serial divider.
// Depends on acsm_pkg and the channel interfaces in acsm_channels.sv.
//
// Each sample word is divided by the scale estimate in a one-bit-per-cycle divider
// (a setup step and 32 steps) and updates both CUSUM sums. When a re-estimation is
// due, the scale division with its product, two bit-serial logarithms through the
// shared multiplier and a 16-step bit-serial power of two with its two products
// follow the sums. On the first sample of a run the scale and limit are loaded first,
// with the logarithms and the power of two skipped. A division that saturates skips
// its 32 steps. The block takes one word at a time; a finished result waits in the
// output register while the next word is accepted, and a word cannot finish while
// that register is still full. After an alarm or the sample cap, words are taken and
// dropped until reset. Configuration is written at any time and takes effect at once.
module adaptive_cusum_scale_monitor_core (
   input logic          clock,
   input logic          reset,
   acsm_req_if.sink     req,
   acsm_rsp_if.source   rsp,
   acsm_csr_if.sink     csr
);

   typedef enum logic [10:0] {
      S_IDLE     = 11'b000_0000_0001,
      S_EST_MUL  = 11'b000_0000_0010,
      S_DIV_INIT = 11'b000_0000_0100,
      S_DIV_RUN  = 11'b000_0000_1000,
      S_LOG_INIT = 11'b000_0001_0000,
      S_LOG_SQ   = 11'b000_0010_0000,
      S_EXP_MUL  = 11'b000_0100_0000,
      S_EXP_LOOP = 11'b000_1000_0000,
      S_LIM_MUL  = 11'b001_0000_0000,
      S_CUSUM    = 11'b010_0000_0000,
      S_FINISH   = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic running_ff, running_in;

   logic [31:0] k_high_ff, k_low_ff, h_base_ff, h_delta_ff, shape_ff;
   logic [15:0] delay_ff, p1cnt_ff;
   logic [47:0] p1sum_ff;

   logic [31:0] alarm_ff, alarm_in, gate_ff, gate_in, scale_ff, scale_in;
   logic [31:0] limit_ff, limit_in, x_ff, x_in, q_ff, q_in;
   logic [47:0] es_ff, es_in;
   logic [16:0] count_ff, count_in, since_ff, since_in;
   logic [15:0] idx_ff, idx_in;
   logic        first_ff, first_in;

   logic [48:0] dnum_ff, dnum_in, dden_ff, dden_in, rem_ff, rem_in;
   logic [31:0] low_ff, low_in, quo_ff, quo_in;
   logic [4:0]  dcnt_ff, dcnt_in;
   logic        dscale_ff, dscale_in;

   logic        pass_ff, pass_in;
   logic [31:0] y_ff, y_in, acc_ff, acc_in;
   logic [20:0] lres_ff, lres_in, la_ff, la_in, ee_ff, ee_in;
   logic [3:0]  step_ff, step_in;
   logic        one_ff, one_in;
   logic [16:0] factor_ff, factor_in;

   logic         rsp_valid_ff, rsp_valid_in;
   acsm_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [16:0] pn;

   logic [49:0] dtrial;
   logic        dge;
   logic [31:0] dquo_next;
   logic [16:0] logv;
   logic [4:0]  loge;
   logic [32:0] sq;
   logic [20:0] lspan;
   logic [32:0] hsum, accv;
   logic [16:0] since_next;
   logic [47:0] es_sum;
   logic [48:0] es_wide;
   logic [16:0] count_next;

   function automatic logic [4:0] msb17(input logic [16:0] v);
      logic [4:0] e;
      e = 5'd0;
      for (int i = 1; i < 17; i++) begin
         if (v[i]) begin
            e = 5'(i);
         end
      end
      return e;
   endfunction

   function automatic logic [31:0] cusum(input logic [31:0] s, input logic [31:0] q,
                                         input logic [31:0] k);
      logic [32:0] t;
      logic [32:0] d;
      t = {1'b0, s} + {1'b0, q};
      d = t - {1'b0, k};
      if (t <= {1'b0, k}) begin
         return 32'd0;
      end else if (d[32]) begin
         return 32'hFFFF_FFFF;
      end
      return d[31:0];
   endfunction

   assign pn = {1'b0, p1cnt_ff} + {1'b0, count_ff[15:0]};

   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      case (state_ff)
         S_EST_MUL: begin
            mul_a = {15'd0, pn};
            mul_b = shape_ff;
         end
         S_LOG_SQ: begin
            mul_a = y_ff;
            mul_b = y_ff;
         end
         S_EXP_MUL: begin
            mul_a = {11'd0, lspan};
            mul_b = acsm_pkg::EXP_085_Q16;
         end
         S_EXP_LOOP: begin
            mul_a = acc_ff;
            mul_b = acsm_pkg::exp_tab(step_ff);
         end
         S_LIM_MUL: begin
            mul_a = h_delta_ff;
            mul_b = {15'd0, factor_ff};
         end
         default: begin
            mul_a = 32'd0;
         end
      endcase
   end

   assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_word_ff;

   always_comb begin
      state_in = state_ff;
      running_in = running_ff;
      alarm_in = alarm_ff;
      gate_in = gate_ff;
      scale_in = scale_ff;
      limit_in = limit_ff;
      x_in = x_ff;
      q_in = q_ff;
      es_in = es_ff;
      count_in = count_ff;
      since_in = since_ff;
      idx_in = idx_ff;
      first_in = first_ff;
      dnum_in = dnum_ff;
      dden_in = dden_ff;
      rem_in = rem_ff;
      low_in = low_ff;
      quo_in = quo_ff;
      dcnt_in = dcnt_ff;
      dscale_in = dscale_ff;
      pass_in = pass_ff;
      y_in = y_ff;
      acc_in = acc_ff;
      lres_in = lres_ff;
      la_in = la_ff;
      ee_in = ee_ff;
      step_in = step_ff;
      one_in = one_ff;
      factor_in = factor_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_word_in = rsp_word_ff;

      dtrial = {rem_ff, low_ff[31]};
      dge = (dtrial >= {1'b0, dden_ff});
      dquo_next = {quo_ff[30:0], dge};
      logv = pass_ff ? {1'b0, p1cnt_ff} : pn;
      loge = msb17(logv);
      sq = mul_p[63:31];
      lspan = (la_ff > lres_ff) ? (la_ff - lres_ff) : 21'd0;
      hsum = {1'b0, h_base_ff} + {1'b0, mul_p[47:16]};
      accv = 33'd0;
      since_next = (since_ff == 17'h1FFFF) ? since_ff : since_ff + 17'd1;
      es_wide = {1'b0, es_ff} + {17'd0, x_ff};
      es_sum = es_wide[48] ? 48'hFFFF_FFFF_FFFF : es_wide[47:0];
      count_next = (count_ff == 17'h1FFFF) ? count_ff : count_ff + 17'd1;

      case (state_ff)
         S_IDLE: begin
            if (req.valid && running_ff) begin
               x_in = req.payload.sample;
               idx_in = count_ff[15:0];
               first_in = (count_ff == 17'd0);
               if (count_ff == 17'd0) begin
                  state_in = S_EST_MUL;
               end else begin
                  dnum_in = {17'd0, req.payload.sample};
                  dden_in = {17'd0, scale_ff};
                  dscale_in = 1'b0;
                  state_in = S_DIV_INIT;
               end
            end
         end
         S_EST_MUL: begin
            dnum_in = {1'b0, p1sum_ff} + {1'b0, es_ff};
            dden_in = mul_p[48:0];
            dscale_in = 1'b1;
            pass_in = 1'b0;
            state_in = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            rem_in = {16'd0, dnum_ff[48:16]};
            low_in = {dnum_ff[15:0], 16'd0};
            quo_in = 32'd0;
            dcnt_in = 5'd0;
            if (dden_ff == 49'd0 || {16'd0, dnum_ff[48:16]} >= dden_ff) begin
               if (dscale_ff) begin
                  scale_in = 32'hFFFF_FFFF;
                  state_in = S_LOG_INIT;
               end else begin
                  q_in = 32'hFFFF_FFFF;
                  state_in = S_CUSUM;
               end
            end else begin
               state_in = S_DIV_RUN;
            end
         end
         S_DIV_RUN: begin
            rem_in = dge ? 49'(dtrial - {1'b0, dden_ff}) : dtrial[48:0];
            low_in = {low_ff[30:0], 1'b0};
            quo_in = dquo_next;
            dcnt_in = dcnt_ff + 5'd1;
            if (dcnt_ff == 5'd31) begin
               if (dscale_ff) begin
                  scale_in = dquo_next;
                  state_in = S_LOG_INIT;
               end else begin
                  q_in = dquo_next;
                  state_in = S_CUSUM;
               end
            end
         end
         S_LOG_INIT: begin
            step_in = 4'd0;
            if (count_ff == 17'd0) begin
               factor_in = 17'h10000;
               state_in = S_LIM_MUL;
            end else if (p1cnt_ff == 16'd0) begin
               factor_in = 17'd0;
               state_in = S_LIM_MUL;
            end else begin
               y_in = {15'd0, logv} << (5'd31 - loge);
               lres_in = {loge, 16'd0};
               state_in = S_LOG_SQ;
            end
         end
         S_LOG_SQ: begin
            lres_in = lres_ff;
            if (sq[32]) begin
               y_in = sq[32:1];
               lres_in[4'd15 - step_ff] = 1'b1;
            end else begin
               y_in = sq[31:0];
            end
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd15) begin
               if (!pass_ff) begin
                  la_in = lres_in;
                  pass_in = 1'b1;
                  state_in = S_LOG_INIT;
               end else begin
                  state_in = S_EXP_MUL;
               end
            end
         end
         S_EXP_MUL: begin
            ee_in = mul_p[36:16];
            step_in = 4'd0;
            one_in = 1'b1;
            pass_in = 1'b0;
            state_in = S_EXP_LOOP;
         end
         S_EXP_LOOP: begin
            if (ee_ff[4'd15 - step_ff]) begin
               one_in = 1'b0;
               acc_in = one_ff ? acsm_pkg::exp_tab(step_ff) : mul_p[63:32];
            end
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd15) begin
               accv = (one_in ? 33'h1_0000_0000 : {1'b0, acc_in}) >> ee_ff[20:16];
               factor_in = accv[32:16];
               state_in = S_LIM_MUL;
            end
         end
         S_LIM_MUL: begin
            limit_in = hsum[32] ? 32'hFFFF_FFFF : hsum[31:0];
            if (first_ff) begin
               first_in = 1'b0;
               dnum_in = {17'd0, x_ff};
               dden_in = {17'd0, scale_ff};
               dscale_in = 1'b0;
               state_in = S_DIV_INIT;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_CUSUM: begin
            alarm_in = cusum(alarm_ff, q_ff, k_high_ff);
            gate_in = cusum(gate_ff, q_ff, k_low_ff);
            since_in = since_next;
            if (gate_in == 32'd0 && since_next >= {1'b0, delay_ff}) begin
               since_in = 17'd0;
               state_in = S_EST_MUL;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp.ready) begin
               es_in = es_sum;
               count_in = count_next;
               rsp_valid_in = 1'b1;
               rsp_word_in.step_index = idx_ff;
               rsp_word_in.cusum_high = alarm_ff;
               rsp_word_in.cusum_low = gate_ff;
               rsp_word_in.limit = limit_ff;
               rsp_word_in.scale_estimate = scale_ff;
               rsp_word_in.status = acsm_pkg::STATUS_IN_CONTROL;
               if (alarm_ff > limit_ff) begin
                  running_in = 1'b0;
                  rsp_word_in.status = acsm_pkg::STATUS_ALARM;
               end else if (count_next >= 17'(acsm_pkg::MAX_SAMPLES)) begin
                  running_in = 1'b0;
                  rsp_word_in.status = acsm_pkg::STATUS_CAP;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         running_ff <= 1'b1;
         alarm_ff <= 32'd0;
         gate_ff <= 32'd0;
         es_ff <= 48'd0;
         count_ff <= 17'd0;
         since_ff <= 17'd0;
         scale_ff <= 32'd0;
         limit_ff <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         running_ff <= running_in;
         alarm_ff <= alarm_in;
         gate_ff <= gate_in;
         es_ff <= es_in;
         count_ff <= count_in;
         since_ff <= since_in;
         scale_ff <= scale_in;
         limit_ff <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      q_ff <= q_in;
      idx_ff <= idx_in;
      first_ff <= first_in;
      dnum_ff <= dnum_in;
      dden_ff <= dden_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      dcnt_ff <= dcnt_in;
      dscale_ff <= dscale_in;
      pass_ff <= pass_in;
      y_ff <= y_in;
      acc_ff <= acc_in;
      lres_ff <= lres_in;
      la_ff <= la_in;
      ee_ff <= ee_in;
      step_ff <= step_in;
      one_ff <= one_in;
      factor_ff <= factor_in;
      rsp_word_ff <= rsp_word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_high_ff <= 32'd32768;
         k_low_ff <= 32'd65536;
         h_base_ff <= 32'd327680;
         h_delta_ff <= 32'd0;
         delay_ff <= 16'd1;
         p1cnt_ff <= 16'd1;
         p1sum_ff <= 48'd65536;
         shape_ff <= 32'd65536;
      end else if (csr.valid) begin
         case (csr.payload.index)
            acsm_pkg::REG_K_HIGH:       k_high_ff <= csr.payload.data[31:0];
            acsm_pkg::REG_K_LOW:        k_low_ff <= csr.payload.data[31:0];
            acsm_pkg::REG_H_BASE:       h_base_ff <= csr.payload.data[31:0];
            acsm_pkg::REG_H_DELTA:      h_delta_ff <= csr.payload.data[31:0];
            acsm_pkg::REG_UPDATE_DELAY: delay_ff <= csr.payload.data[15:0];
            acsm_pkg::REG_PHASE1_COUNT: p1cnt_ff <= csr.payload.data[15:0];
            acsm_pkg::REG_PHASE1_SUM:   p1sum_ff <= csr.payload.data;
            acsm_pkg::REG_SHAPE_VALUE:  shape_ff <= csr.payload.data[31:0];
            default: begin
            end
         endcase
      end
   end

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req.ready)
      else $error("Input taken while a word is in progress.");

   a_stop_sticks: assert property (@(posedge clock) disable iff (reset)
      !running_ff |=> !running_ff)
      else $error("Run restarted without reset.");

   a_stop_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !rsp_valid_ff && rsp_word_in.status != acsm_pkg::STATUS_IN_CONTROL)
      |=> !running_ff)
      else $error("Alarm or cap reported while still running.");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV_RUN) |-> (rem_ff < dden_ff))
      else $error("Divider remainder out of range.");

endmodule
